// ===== rtl/gie_pkg.sv =====
// ============================================================================
// gie_pkg: shared types and constants for the Gini index engine
// Sequencer states, status codes and divider handshake type.
// ============================================================================
package gie_pkg;

    // Result fraction width (unsigned Q0.16)
    localparam int FRAC_BITS = 16;

    // Divider step counter width, holds 0..FRAC_BITS
    localparam int DIV_CNT_W = $clog2(FRAC_BITS + 1);

    typedef logic [1:0] status_t;

    localparam status_t STAT_OK       = 2'd0;
    localparam status_t STAT_ZERO_SUM = 2'd1;
    localparam status_t STAT_TOO_MANY = 2'd2;

    typedef enum logic [2:0] {
        S_COLLECT,
        S_MUL,
        S_RD_A,
        S_RD_B,
        S_PAIR,
        S_DIV_START,
        S_DIV_WAIT,
        S_DONE
    } state_t;

    // Divider status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== rtl/gie_frac_div.sv =====
// ============================================================================
// gie_frac_div: fraction divider
// Restoring division, one quotient bit per cycle: floor(num * 2^16 / den)
// for num < den.
// ============================================================================
module gie_frac_div #(
    parameter int ACC_W = 54
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ACC_W-1:0]           num,
    input  logic [ACC_W-1:0]           den,
    output gie_pkg::div_stat_t         stat,
    output logic [gie_pkg::FRAC_BITS-1:0] quotient
);
    import gie_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 done_reg;
    logic                 done_next;
    logic [ACC_W-1:0]     rem_reg;
    logic [ACC_W-1:0]     rem_next;
    logic [ACC_W-1:0]     den_reg;
    logic [FRAC_BITS-1:0] quo_reg;
    logic [FRAC_BITS-1:0] quo_next;
    logic [ACC_W:0]       rem_dbl;
    logic [ACC_W:0]       rem_sub;
    logic                 fits;

    always_comb
    begin
        rem_dbl   = {rem_reg, 1'b0};
        rem_sub   = rem_dbl - {1'b0, den_reg};
        fits      = (rem_dbl >= {1'b0, den_reg});
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = DIV_CNT_W'(FRAC_BITS);
            rem_next = num;
            quo_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CNT_W'(1));
            quo_next  = {quo_reg[FRAC_BITS-2:0], fits};
            // remainder stays below den, so the doubled value drops its top bit safely
            rem_next  = fits ? rem_sub[ACC_W-1:0] : rem_dbl[ACC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ===== rtl/gini_index_engine.sv =====
// ============================================================================
// gini_index_engine: Gini index of a set of unsigned samples
// Stores a set, then walks all unordered pairs in the sample memory and
// divides the absolute-difference total by count times sum.
// ============================================================================
//
//  channel | ports                              | direction | word
//  --------+------------------------------------+-----------+------------------
//  in      | in_valid, in_stall, sample_value,  | to block  | one sample,
//          | last_sample                        |           | last marks end
//  out     | out_valid, out_stall,              | from block| one result per
//          | gini_fraction, status              |           | set
//
//  Samples are taken one per cycle while collecting (in_stall low).
//  After the last word the final pass runs with in_stall high: n * sum by
//  shift-add, the pair walk over each outer index i through the single
//  memory read port, the divider, and then the load of the result.
//  Reset clears count, sum, overflow flag and the output valid; the sample
//  memory is not cleared, only entries of the current set are ever used.
//  A stalled result is held in the output register; a new set can be
//  collected meanwhile, and its result waits in the done state until the
//  output register frees up.
//
module gini_index_engine #(
    parameter int MAX_VALUES = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [31:0]                   sample_value,
    input  logic                          last_sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [gie_pkg::FRAC_BITS-1:0] gini_fraction,
    output gie_pkg::status_t              status
);
    import gie_pkg::*;

    localparam int ADDR_W = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int CNT_W  = $clog2(MAX_VALUES + 1);
    localparam int SUM_W  = VALUE_BITS + CNT_W;
    // pair total and n * sum both fit here
    localparam int ACC_W  = VALUE_BITS + 2 * CNT_W;

    // sample memory: one write port (collect), one registered read port (walk)
    logic [VALUE_BITS-1:0] sample_mem [MAX_VALUES];
    logic [VALUE_BITS-1:0] rd_data_reg;
    logic [ADDR_W-1:0]     rd_addr;

    state_t                state_reg;
    state_t                state_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [SUM_W-1:0]      sum_reg;
    logic [SUM_W-1:0]      sum_next;
    logic                  ovf_reg;
    logic                  ovf_next;
    logic [CNT_W-1:0]      i_reg;
    logic [CNT_W-1:0]      i_next;
    logic [CNT_W-1:0]      j_reg;
    logic [CNT_W-1:0]      j_next;
    logic                  pend_reg;
    logic                  pend_next;
    logic [VALUE_BITS-1:0] a_reg;
    logic [ACC_W-1:0]      acc_reg;
    logic [ACC_W-1:0]      den_reg;
    logic [ACC_W-1:0]      mcand_reg;
    logic [CNT_W-1:0]      mplier_reg;
    logic                  out_valid_reg;
    logic [FRAC_BITS-1:0]  gini_reg;
    status_t               status_reg;

    logic                  in_accept;
    logic                  store_ok;
    logic [VALUE_BITS-1:0] value;
    logic                  mul_init;
    logic                  out_load;
    logic                  div_start;
    logic [VALUE_BITS-1:0] abs_diff;
    logic [CNT_W:0]        i_plus2;
    div_stat_t             div_stat;
    logic [FRAC_BITS-1:0]  div_quo;
    status_t               status_new;

    assign value     = sample_value[VALUE_BITS-1:0];
    assign in_stall  = (state_reg != S_COLLECT);
    assign in_accept = in_valid && !in_stall;
    assign store_ok  = (cnt_reg != CNT_W'(MAX_VALUES));
    assign abs_diff  = (a_reg >= rd_data_reg) ? (a_reg - rd_data_reg)
                                              : (rd_data_reg - a_reg);
    assign i_plus2   = {1'b0, i_reg} + (CNT_W + 1)'(2);
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // next state and control
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        pend_next  = 1'b0;
        mul_init   = 1'b0;
        div_start  = 1'b0;
        rd_addr    = i_reg[ADDR_W-1:0];
        case (state_reg)
            S_COLLECT:
            begin
                if (in_accept)
                begin
                    if (store_ok)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        sum_next = sum_reg + SUM_W'(value);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_sample)
                    begin
                        // zero sum skips the whole final pass
                        if (sum_next == '0)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            mul_init   = 1'b1;
                            state_next = S_MUL;
                        end
                    end
                end
            end
            S_MUL:
            begin
                if (mplier_reg == '0)
                begin
                    if (cnt_reg >= CNT_W'(2))
                    begin
                        i_next     = '0;
                        state_next = S_RD_A;
                    end
                    else
                    begin
                        state_next = S_DIV_START;
                    end
                end
            end
            S_RD_A:
            begin
                rd_addr    = i_reg[ADDR_W-1:0];
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                j_next     = i_reg + 1'b1;
                state_next = S_PAIR;
            end
            S_PAIR:
            begin
                rd_addr = j_reg[ADDR_W-1:0];
                if (j_reg < cnt_reg)
                begin
                    pend_next = 1'b1;
                    j_next    = j_reg + 1'b1;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    if (i_plus2 < {1'b0, cnt_reg})
                    begin
                        state_next = S_RD_A;
                    end
                    else
                    begin
                        state_next = S_DIV_START;
                    end
                end
            end
            S_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    cnt_next   = '0;
                    sum_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = S_COLLECT;
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_COLLECT;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            ovf_reg   <= ovf_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            pend_reg  <= pend_next;
        end
    end

    // sample memory
    always_ff @(posedge clk)
    begin
        if (in_accept && store_ok)
        begin
            sample_mem[cnt_reg[ADDR_W-1:0]] <= value;
        end
        rd_data_reg <= sample_mem[rd_addr];
    end

    // datapath: shift-add multiply, pair accumulation
    always_ff @(posedge clk)
    begin
        if (mul_init)
        begin
            den_reg    <= '0;
            mcand_reg  <= ACC_W'(sum_next);
            mplier_reg <= cnt_next;
        end
        else if (state_reg == S_MUL && mplier_reg != '0)
        begin
            if (mplier_reg[0])
            begin
                den_reg <= den_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[ACC_W-2:0], 1'b0};
            mplier_reg <= mplier_reg >> 1;
        end

        if (mul_init)
        begin
            acc_reg <= '0;
        end
        else if (pend_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(abs_diff);
        end

        if (state_reg == S_RD_B)
        begin
            a_reg <= rd_data_reg;
        end
    end

    gie_frac_div #(
        .ACC_W (ACC_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (acc_reg),
        .den      (den_reg),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    // result register
    always_comb
    begin
        if (ovf_reg)
        begin
            status_new = STAT_TOO_MANY;
        end
        else if (sum_reg == '0)
        begin
            status_new = STAT_ZERO_SUM;
        end
        else
        begin
            status_new = STAT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            gini_reg   <= (sum_reg == '0) ? '0 : div_quo;
            status_reg <= status_new;
        end
    end

    assign out_valid     = out_valid_reg;
    assign gini_fraction = gini_reg;
    assign status        = status_reg;

`ifndef SYNTHESIS
    // count never runs past the store depth
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_VALUES))
        else $error("sample count past store depth");

    // pair total stays below n * sum, so the fraction is below one
    a_frac_below_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_START) |-> (acc_reg < den_reg))
        else $error("pair total not below n * sum");

    // pending reads only occur during the pair walk
    a_pend_walk: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == S_PAIR || state_reg == S_RD_A))
        else $error("pair read outside walk");

    // a result clears the set state
    a_clear_after: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (cnt_reg == '0 && sum_reg == '0 && !ovf_reg && out_valid_reg))
        else $error("set state not cleared after result");

    // divider is idle whenever the sequencer starts it
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");
`endif

endmodule
